// ===== sv/rau_pkg.sv =====
// rau_pkg: shared types and constants for the rational arithmetic unit
// no dependencies
package rau_pkg;
   localparam int unsigned ProdWidth = 64;

   typedef enum logic [1:0] {
      CMD_ADD = 2'd0,
      CMD_SUB = 2'd1,
      CMD_MUL = 2'd2,
      CMD_DIV = 2'd3
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_M1, ST_M2, ST_M3, ST_GCD, ST_Q1, ST_Q2, ST_FIN, ST_OUT
   } state_type;

   typedef logic [ProdWidth-1:0] word_type;
endpackage

// ===== sv/rau_mul.sv =====
// rau_mul: bit-serial signed multiplier, one multiplier bit per cycle
// depends on rau_pkg
module rau_mul (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  rau_pkg::word_type   mcand,
   input  rau_pkg::word_type   mplier,
   output logic                done,
   output rau_pkg::word_type   product
);
   import rau_pkg::*;

   localparam int unsigned CntWidth = $clog2(ProdWidth + 1);

   word_type mcand_ff, mcand_in;
   word_type mplier_ff, mplier_in;
   word_type acc_ff, acc_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;

   always_comb begin
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (start) begin
         mcand_in  = mcand;
         mplier_in = mplier;
         acc_in    = '0;
         cnt_in    = CntWidth'(ProdWidth);
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         if (mplier_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in  = {mcand_ff[ProdWidth-2:0], 1'b0};
         mplier_in = {1'b0, mplier_ff[ProdWidth-1:1]};
         cnt_in    = cnt_ff - 1'b1;
         if (cnt_ff == CntWidth'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      acc_ff    <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;
endmodule

// ===== sv/rau_div.sv =====
// rau_div: restoring unsigned divider, one quotient bit per cycle
// depends on rau_pkg
module rau_div (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  rau_pkg::word_type   dividend,
   input  rau_pkg::word_type   divisor,
   output logic                done,
   output rau_pkg::word_type   quotient,
   output rau_pkg::word_type   remainder
);
   import rau_pkg::*;

   localparam int unsigned CntWidth = $clog2(ProdWidth + 1);

   word_type quo_ff, quo_in;
   word_type rem_ff, rem_in;
   word_type dsr_ff, dsr_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [ProdWidth:0] trial;
   logic [ProdWidth:0] shifted;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff, quo_ff[ProdWidth-1]};
      trial   = shifted - {1'b0, dsr_ff};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = CntWidth'(ProdWidth);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[ProdWidth]) begin
            rem_in = trial[ProdWidth-1:0];
            quo_in = {quo_ff[ProdWidth-2:0], 1'b1};
         end else begin
            rem_in = shifted[ProdWidth-1:0];
            quo_in = {quo_ff[ProdWidth-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntWidth'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;
endmodule

// ===== sv/rational_arith_unit_top.sv =====
// rational_arith_unit_top: rational add, subtract, multiply and divide
// sequencing: add/sub with equal denominators is done in ST_M1 without the multiplier, otherwise
// three serial products; mul/div take two products, then euclid steps on the divider, then two
// divisions for reduction when the gcd exceeds one and ST_FIN, on the bit-serial units
// throughput: one item at a time, next beat can be accepted from the cycle after the result beat is taken
// reset: synchronous active high, clears control state, unit returns to idle
// depends on rau_pkg, rau_mul, rau_div
module rational_arith_unit_top #(
   parameter int OPERAND_WIDTH = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic [1:0]   req_command,
   input  logic signed [31:0] req_a_num,
   input  logic signed [31:0] req_a_den,
   input  logic signed [31:0] req_b_num,
   input  logic signed [31:0] req_b_den,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic signed [63:0] rsp_res_num,
   output logic signed [63:0] rsp_res_den,
   output logic         rsp_den_zero
);
   import rau_pkg::*;

   state_type state_ff, state_in;
   cmd_type   cmd_ff;
   word_type  an_ff, ad_ff, bn_ff, bd_ff;
   word_type  p_ff, q_ff, r_ff, x_ff, y_ff;
   word_type  rn_ff, rd_ff;

   logic      mul_start, mul_done, div_start, div_done;
   word_type  mul_a, mul_b, mul_p;
   word_type  div_n, div_d, div_q, div_r;
   word_type  mn, md;

   function automatic word_type sext(input logic [31:0] v);
      logic [31:0] t;
      t = v;
      for (int i = 0; i < 32; i++) begin
         if (i >= OPERAND_WIDTH) begin
            t[i] = v[OPERAND_WIDTH-1];
         end
      end
      return {{32{t[31]}}, t};
   endfunction

   function automatic word_type mag(input word_type v);
      return v[ProdWidth-1] ? (word_type'(0) - v) : v;
   endfunction

   assign mn = mag(p_ff);
   assign md = mag(q_ff);

   rau_mul u_mul (
      .clock(clock), .reset(reset), .start(mul_start),
      .mcand(mul_a), .mplier(mul_b), .done(mul_done), .product(mul_p)
   );

   rau_div u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(div_n), .divisor(div_d), .done(div_done),
      .quotient(div_q), .remainder(div_r)
   );

   logic accept;
   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_res_num  = rn_ff;
   assign rsp_res_den  = rd_ff;
   assign rsp_den_zero = (rd_ff == '0);

   logic addsub, same;
   assign addsub = (cmd_ff == CMD_ADD) || (cmd_ff == CMD_SUB);
   assign same   = (ad_ff == bd_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept) state_in = ST_M1;
         ST_M1: begin
            if (addsub && same) state_in = ST_OUT;
            else if (mul_done) state_in = ST_M2;
         end
         ST_M2: if (mul_done) state_in = addsub ? ST_M3 : ST_GCD;
         ST_M3: if (mul_done) state_in = ST_OUT;
         ST_GCD: begin
            if (y_ff == '0) begin
               state_in = (x_ff > word_type'(1)) ? ST_Q1 : ST_FIN;
            end
         end
         ST_Q1: if (div_done) state_in = ST_Q2;
         ST_Q2: if (div_done) state_in = ST_FIN;
         ST_FIN: state_in = ST_OUT;
         ST_OUT: if (rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // unit starts and operand selection
   logic run_ff;
   always_comb begin
      mul_start = 1'b0;
      div_start = 1'b0;
      mul_a = an_ff;
      mul_b = bd_ff;
      div_n = x_ff;
      div_d = y_ff;
      unique case (state_ff)
         ST_M1: begin
            mul_start = !run_ff && !(addsub && same);
            mul_a = an_ff;
            mul_b = (cmd_ff == CMD_MUL) ? bn_ff : bd_ff;
         end
         ST_M2: begin
            mul_start = !run_ff;
            if (addsub) begin
               mul_a = bn_ff;
               mul_b = ad_ff;
            end else begin
               mul_a = ad_ff;
               mul_b = (cmd_ff == CMD_MUL) ? bd_ff : bn_ff;
            end
         end
         ST_M3: begin
            mul_start = !run_ff;
            mul_a = ad_ff;
            mul_b = bd_ff;
         end
         ST_GCD: begin
            div_start = !run_ff && (y_ff != '0);
            div_n = x_ff;
            div_d = y_ff;
         end
         ST_Q1: begin
            div_start = !run_ff;
            div_n = mn;
            div_d = x_ff;
         end
         ST_Q2: begin
            div_start = !run_ff;
            div_n = md;
            div_d = x_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         run_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (mul_start || div_start) run_ff <= 1'b1;
         else if (mul_done || div_done) run_ff <= 1'b0;
      end
      if (accept) begin
         cmd_ff <= cmd_type'(req_command);
         an_ff  <= sext(req_a_num);
         ad_ff  <= sext(req_a_den);
         bn_ff  <= sext(req_b_num);
         bd_ff  <= sext(req_b_den);
      end
      unique case (state_ff)
         ST_M1: begin
            if (addsub && same) begin
               rn_ff <= (cmd_ff == CMD_ADD) ? an_ff + bn_ff : an_ff - bn_ff;
               rd_ff <= ad_ff;
            end else if (mul_done) begin
               p_ff <= mul_p;
            end
         end
         ST_M2: begin
            if (mul_done) begin
               q_ff <= mul_p;
               if (addsub) begin
                  rn_ff <= (cmd_ff == CMD_ADD) ? p_ff + mul_p : p_ff - mul_p;
               end else begin
                  x_ff <= mag(p_ff);
                  y_ff <= mag(mul_p);
               end
            end
         end
         ST_M3: if (mul_done) rd_ff <= mul_p;
         ST_GCD: begin
            if (div_done) begin
               x_ff <= y_ff;
               y_ff <= div_r;
            end
            if (y_ff == '0) begin
               r_ff <= mn;
               rd_ff <= md;
            end
         end
         ST_Q1: if (div_done) r_ff <= div_q;
         ST_Q2: if (div_done) rd_ff <= div_q;
         ST_FIN: begin
            rn_ff <= ((p_ff[ProdWidth-1] ^ q_ff[ProdWidth-1]) && (r_ff != '0))
                     ? word_type'(0) - r_ff : r_ff;
         end
         default: begin
         end
      endcase
   end
endmodule

// ===== test/rational_arith_unit_top_test.sv =====
// rational_arith_unit_top_test: self-checking bench for the rational arithmetic unit
// drives directed and random fraction beats and checks every result against a local predictor
// depends on rau_pkg and rational_arith_unit_top
`timescale 1ns / 100ps

module rational_arith_unit_top_test;
   import rau_pkg::*;

   typedef struct {
      cmd_type cmd;
      logic signed [31:0] an;
      logic signed [31:0] ad;
      logic signed [31:0] bn;
      logic signed [31:0] bd;
      bit drain;
   } fraction_req_type;

   typedef struct {
      logic [63:0] num;
      logic [63:0] den;
      logic zero;
   } fraction_res_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [1:0] req_command;
   logic signed [31:0] req_a_num;
   logic signed [31:0] req_a_den;
   logic signed [31:0] req_b_num;
   logic signed [31:0] req_b_den;
   logic rsp_valid;
   logic rsp_ready;
   logic signed [63:0] rsp_res_num;
   logic signed [63:0] rsp_res_den;
   logic rsp_den_zero;

   fraction_req_type pending_q[$];
   fraction_res_type expected_q[$];
   int error_count = 0;
   int result_count = 0;
   int gap_left = 0;
   int hold_left = 0;
   bit burst_mode = 0;
   bit long_hold_done = 0;

   rational_arith_unit_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_command(req_command),
      .req_a_num(req_a_num), .req_a_den(req_a_den),
      .req_b_num(req_b_num), .req_b_den(req_b_den),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_res_num(rsp_res_num), .rsp_res_den(rsp_res_den),
      .rsp_den_zero(rsp_den_zero)
   );

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   function automatic fraction_res_type compute_fraction(cmd_type cmd, logic signed [31:0] an_i,
         logic signed [31:0] ad_i, logic signed [31:0] bn_i, logic signed [31:0] bd_i);
      longint unsigned an, ad, bn, bd, pn, pd, mn, md, x, y, t;
      fraction_res_type r;
      an = longint'(an_i);
      ad = longint'(ad_i);
      bn = longint'(bn_i);
      bd = longint'(bd_i);
      if (cmd == CMD_ADD || cmd == CMD_SUB) begin
         if (ad != bd) begin
            pn = an * bd;
            pd = bn * ad;
            r.num = (cmd == CMD_ADD) ? pn + pd : pn - pd;
            r.den = ad * bd;
         end else begin
            r.num = (cmd == CMD_ADD) ? an + bn : an - bn;
            r.den = ad;
         end
      end else begin
         if (cmd == CMD_MUL) begin
            pn = an * bn;
            pd = ad * bd;
         end else begin
            pn = an * bd;
            pd = ad * bn;
         end
         mn = pn[63] ? -pn : pn;
         md = pd[63] ? -pd : pd;
         x = mn;
         y = md;
         while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
         end
         if (x > 1) begin
            mn = mn / x;
            md = md / x;
         end
         r.num = ((pn[63] ^ pd[63]) && mn != 0) ? -mn : mn;
         r.den = md;
      end
      r.zero = (r.den == 0);
      return r;
   endfunction

   function automatic logic signed [31:0] rand_operand(bit wide);
      logic signed [31:0] v;
      if (wide) begin
         v = $urandom;
         if (v == 32'sh8000_0000)
            v = 32'sh8000_0001;
      end else begin
         v = $urandom_range(0, 40);
         if ($urandom_range(0, 1))
            v = -v;
      end
      return v;
   endfunction

   task automatic add_req(cmd_type c, int an, int ad, int bn, int bd, bit drain);
      fraction_req_type it;
      it.cmd = c;
      it.an = an;
      it.ad = ad;
      it.bn = bn;
      it.bd = bd;
      it.drain = drain;
      pending_q.push_back(it);
   endtask

   task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] exp);
      error_count++;
      $display("mismatch on %s: got %0d expected %0d", field, $signed(got), $signed(exp));
   endtask

   // driver
   always @(posedge clock) begin
      fraction_req_type it;
      if (reset) begin
         req_valid <= 0;
         gap_left <= 0;
      end else if (req_valid && req_ready) begin
         expected_q.push_back(compute_fraction(cmd_type'(req_command), req_a_num, req_a_den,
                                               req_b_num, req_b_den));
         if ($urandom_range(0, 40) == 0)
            burst_mode = ~burst_mode;
         gap_left <= burst_mode ? 0 : $urandom_range(0, 18);
         req_valid <= 0;
      end else if (!req_valid) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
         end else if (pending_q.size() > 0 && !(pending_q[0].drain && expected_q.size() > 0)) begin
            it = pending_q.pop_front();
            req_command <= it.cmd;
            req_a_num <= it.an;
            req_a_den <= it.ad;
            req_b_num <= it.bn;
            req_b_den <= it.bd;
            req_valid <= 1;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      fraction_res_type exp;
      int n;
      if (reset) begin
         rsp_ready <= 0;
         hold_left <= 0;
      end else if (rsp_valid && rsp_ready) begin
         result_count++;
         if (expected_q.size() == 0) begin
            report_mismatch("unexpected beat", rsp_res_num, 64'd0);
         end else begin
            exp = expected_q.pop_front();
            if (rsp_res_num !== exp.num)
               report_mismatch("res_num", rsp_res_num, exp.num);
            if (rsp_res_den !== exp.den)
               report_mismatch("res_den", rsp_res_den, exp.den);
            if (rsp_den_zero !== exp.zero)
               report_mismatch("den_zero", 64'(rsp_den_zero), 64'(exp.zero));
         end
         n = burst_mode ? 0 : $urandom_range(0, 18);
         if (result_count == 150 && !long_hold_done) begin
            n = 900;
            long_hold_done = 1;
         end
         hold_left <= n;
         rsp_ready <= (n == 0);
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= (hold_left == 1);
      end else begin
         rsp_ready <= 1;
      end
   end

   initial begin
      cmd_type c;
      reset = 1;
      req_valid = 0;
      rsp_ready = 0;
      req_command = 0;
      req_a_num = 0;
      req_a_den = 0;
      req_b_num = 0;
      req_b_den = 0;

      // directed extremes and corner cases per operation
      for (int k = 0; k < 4; k++) begin
         c = cmd_type'(k);
         add_req(c, 2147483647, 2147483647, -2147483647, -2147483647, 0);
         add_req(c, -2147483647, 3, 2147483647, -2147483647, 0);
         add_req(c, 5, 0, 7, 3, 0);
         add_req(c, 0, 4, 0, 9, 0);
         add_req(c, 6, -4, 3, 4, 0);
      end
      add_req(CMD_MUL, 0, 0, 5, 0, 0);
      add_req(CMD_DIV, 3, 0, 2, 5, 0);
      add_req(CMD_DIV, -3, 5, 0, 7, 0);
      add_req(CMD_ADD, 1, -1, -1, 1, 0);

      for (int i = 0; i < 830; i++) begin
         bit wide;
         fraction_req_type it;
         wide = ($urandom_range(0, 99) < 15);
         it.cmd = cmd_type'($urandom_range(0, 3));
         it.an = rand_operand(wide);
         it.ad = rand_operand(wide);
         it.bn = rand_operand(wide);
         it.bd = rand_operand(wide);
         if ($urandom_range(0, 3) == 0)
            it.bd = it.ad;
         it.drain = (i == 400);
         pending_q.push_back(it);
      end

      repeat (5) @(posedge clock);
      reset <= 0;

      while (pending_q.size() > 0 || req_valid || expected_q.size() > 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
      if (error_count == 0 && expected_q.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #200_000_000;
      $display("CHECKS FAILED");
      $finish;
   end
endmodule
